// ----- rtl/core/segment_chain_grouper_core_assert.svh -----
// ----------------------------------------------------------------------------
// segment_chain_grouper_core_assert
// Assertion macros shared by the core RTL.
// ASRT_IMP:  antecedent and consequent in the same cycle.
// ASRT_NXT:  consequent in the cycle after the antecedent.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CHAIN_GROUPER_CORE_ASSERT_SVH
`define SEGMENT_CHAIN_GROUPER_CORE_ASSERT_SVH

`define ASRT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASRT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/scg_pkg.sv -----
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types, constants and the point-match compare of the segment chain
// grouper.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 65536;

    // Configuration space: one register, byte address 0.
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam logic        REG_MATCH_TOL = 1'b0;   // word index, paddr[2]
    localparam logic [30:0] TOL_RESET     = 31'd66;

    // Result queue.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] chain_first;
        logic [16:0] chain_length;
        logic        chain_closed;
        logic [15:0] chain_number;
        logic        last_chain;
    } rec_t;

    // Records produced for one segment; rec_a is written first.
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec_a;
        rec_t       rec_b;
    } push_t;

    // |a - b| <= tol, done as -tol <= d <= tol on a 33-bit difference.
    function automatic logic near_equal(input logic [31:0] a,
                                        input logic [31:0] b,
                                        input logic [30:0] tol);
        logic signed [32:0] d;
        logic signed [32:0] t;
        d = $signed({a[31], a}) - $signed({b[31], b});
        t = $signed({2'b00, tol});
        return (d <= t) && (d >= -t);
    endfunction

    function automatic logic points_meet(input logic [31:0] ax,
                                         input logic [31:0] ay,
                                         input logic [31:0] bx,
                                         input logic [31:0] by,
                                         input logic [30:0] tol);
        return near_equal(ax, bx, tol) && near_equal(ay, by, tol);
    endfunction

endpackage

// ----- rtl/core/scg_regs.sv -----
// ----------------------------------------------------------------------------
// scg_regs
// APB register file: holds the match tolerance.
// ----------------------------------------------------------------------------
module scg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [30:0]                      match_tolerance
);

    logic [30:0] tol_reg;
    logic [30:0] tol_next;
    logic        hit_tol;

    assign pready  = 1'b1;
    assign hit_tol = (paddr[2] == scg_pkg::REG_MATCH_TOL);

    always_comb begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && hit_tol) begin
            tol_next = pwdata[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= scg_pkg::TOL_RESET;
        end else begin
            tol_reg <= tol_next;
        end
    end

    assign prdata          = hit_tol ? {1'b0, tol_reg} : 32'd0;
    assign match_tolerance = tol_reg;

endmodule

// ----- rtl/core/scg_tracker.sv -----
// ----------------------------------------------------------------------------
// scg_tracker
// Input register plus chain state. Each segment is judged from the input register and
// yields zero, one or two records for the result queue.
// ----------------------------------------------------------------------------
module scg_tracker #(
    parameter int unsigned MAX_SEGMENTS = scg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_start_x,
    input  logic [31:0]         s_start_y,
    input  logic [31:0]         s_end_x,
    input  logic [31:0]         s_end_y,
    input  logic                s_last_segment,
    input  logic [30:0]         match_tolerance,
    input  logic                room_ok,
    output scg_pkg::push_t      push
);

    localparam logic [16:0] LEN_CAP = 17'((MAX_SEGMENTS < 65536) ? MAX_SEGMENTS : 65536);

    // input register
    logic        in_vld_reg;
    logic [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic        last_reg;

    // chain state
    logic        active_reg,  active_next;
    logic [31:0] fsx_reg,     fsx_next;
    logic [31:0] fsy_reg,     fsy_next;
    logic [31:0] pex_reg,     pex_next;
    logic [31:0] pey_reg,     pey_next;
    logic [15:0] seg_idx_reg, seg_idx_next;
    logic [15:0] cur_first_reg, cur_first_next;
    logic [16:0] cur_len_reg, cur_len_next;
    logic [15:0] chains_reg,  chains_next;

    logic        go;
    logic        joined;
    logic        brk;
    logic [15:0] num_after;
    scg_pkg::rec_t rec_brk;
    scg_pkg::rec_t rec_fin;

    assign go      = in_vld_reg && room_ok;
    assign s_ready = !in_vld_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sx_reg   <= s_start_x;
            sy_reg   <= s_start_y;
            ex_reg   <= s_end_x;
            ey_reg   <= s_end_y;
            last_reg <= s_last_segment;
        end
    end

    always_comb begin
        joined = active_reg &&
                 scg_pkg::points_meet(pex_reg, pey_reg, sx_reg, sy_reg, match_tolerance);
        brk    = active_reg && !joined;
        num_after = chains_reg + {15'd0, brk};

        if (joined) begin
            cur_len_next   = (cur_len_reg < LEN_CAP) ? cur_len_reg + 17'd1 : cur_len_reg;
            cur_first_next = cur_first_reg;
            fsx_next       = fsx_reg;
            fsy_next       = fsy_reg;
        end else begin
            cur_len_next   = 17'd1;
            cur_first_next = seg_idx_reg;
            fsx_next       = sx_reg;
            fsy_next       = sy_reg;
        end

        // record of the chain that just broke
        rec_brk.chain_first  = cur_first_reg;
        rec_brk.chain_length = cur_len_reg;
        rec_brk.chain_closed = (cur_len_reg > 17'd1) &&
            scg_pkg::points_meet(pex_reg, pey_reg, fsx_reg, fsy_reg, match_tolerance);
        rec_brk.chain_number = chains_reg;
        rec_brk.last_chain   = 1'b0;

        // end-of-list record; a freshly started chain has length one, never closed
        rec_fin.chain_first  = cur_first_next;
        rec_fin.chain_length = cur_len_next;
        rec_fin.chain_closed = joined && (cur_len_next > 17'd1) &&
            scg_pkg::points_meet(ex_reg, ey_reg, fsx_reg, fsy_reg, match_tolerance);
        rec_fin.chain_number = num_after;
        rec_fin.last_chain   = 1'b1;

        push.rec_a = brk ? rec_brk : rec_fin;
        push.rec_b = rec_fin;
        push.cnt   = go ? ({1'b0, brk} + {1'b0, last_reg}) : 2'd0;

        pex_next     = ex_reg;
        pey_next     = ey_reg;
        active_next  = !last_reg;
        seg_idx_next = last_reg ? 16'd0 : seg_idx_reg + 16'd1;
        chains_next  = last_reg ? 16'd0 : num_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            fsx_reg       <= '0;
            fsy_reg       <= '0;
            pex_reg       <= '0;
            pey_reg       <= '0;
            seg_idx_reg   <= '0;
            cur_first_reg <= '0;
            cur_len_reg   <= '0;
            chains_reg    <= '0;
        end else if (go) begin
            active_reg    <= active_next;
            fsx_reg       <= fsx_next;
            fsy_reg       <= fsy_next;
            pex_reg       <= pex_next;
            pey_reg       <= pey_next;
            seg_idx_reg   <= seg_idx_next;
            cur_first_reg <= cur_first_next;
            cur_len_reg   <= cur_len_next;
            chains_reg    <= chains_next;
        end
    end

endmodule

// ----- rtl/core/scg_out_fifo.sv -----
// ----------------------------------------------------------------------------
// scg_out_fifo
// Small result queue: takes up to two records a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module scg_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scg_pkg::push_t                push,
    output logic                          room_ok,
    output logic [scg_pkg::FIFO_CW-1:0]   count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output scg_pkg::rec_t                 head
);

    localparam int unsigned AW = scg_pkg::FIFO_AW;
    localparam int unsigned CW = scg_pkg::FIFO_CW;

    scg_pkg::rec_t mem_reg [scg_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;
    logic [AW-1:0] wr_ptr_p1;

    assign pop       = m_valid && m_ready;
    assign wr_ptr_p1 = wr_ptr_reg + AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.rec_a;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.rec_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // need space for a worst-case segment (two records)
    assign room_ok = (count_reg <= CW'(scg_pkg::FIFO_DEPTH - 2));
    assign count   = count_reg;
    assign m_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/segment_chain_grouper_core.sv -----
// ----------------------------------------------------------------------------
// segment_chain_grouper_core
// Groups a stream of line segments into chains of touching segments and
// emits one record per chain.
// ----------------------------------------------------------------------------
//  channel   ports            beat
//  segment   s_valid/s_ready  start/end point (Q16.16) and last-of-list mark
//  record    m_valid/m_ready  first index, length, closed, number, last mark
//  config    APB (psel..)     match tolerance at byte address 0
//
//  One segment per cycle while the FIFO has room; a segment is judged in the
//  cycle after its beat and its records are then written into the FIFO.
//  Records queue in a four-entry FIFO; the segment side stalls while fewer
//  than two entries are free, so sustained rate is one segment per cycle
//  while m_ready keeps up with the record rate.
//  aresetn is synchronous; reset clears all chain state and the tolerance
//  returns to 66.
// ----------------------------------------------------------------------------
module segment_chain_grouper_core #(
    parameter int unsigned MAX_SEGMENTS = scg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_start_x,
    input  logic signed [31:0]               s_start_y,
    input  logic signed [31:0]               s_end_x,
    input  logic signed [31:0]               s_end_y,
    input  logic                             s_last_segment,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [15:0]                      m_chain_first,
    output logic [16:0]                      m_chain_length,
    output logic                             m_chain_closed,
    output logic [15:0]                      m_chain_number,
    output logic                             m_last_chain
);

    logic [30:0]                     match_tolerance;
    logic                            room_ok;
    logic [scg_pkg::FIFO_CW-1:0]     fifo_count;
    scg_pkg::push_t                  push;
    scg_pkg::rec_t                   head;

    scg_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .match_tolerance (match_tolerance)
    );

    scg_tracker #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_last_segment  (s_last_segment),
        .match_tolerance (match_tolerance),
        .room_ok         (room_ok),
        .push            (push)
    );

    scg_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room_ok (room_ok),
        .count   (fifo_count),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_chain_first  = head.chain_first;
    assign m_chain_length = head.chain_length;
    assign m_chain_closed = head.chain_closed;
    assign m_chain_number = head.chain_number;
    assign m_last_chain   = head.last_chain;

`include "segment_chain_grouper_core_assert.svh"

    // queue never overflows
    `ASRT_IMP(a_fifo_bound, aclk, aresetn, 1'b1,
              fifo_count <= scg_pkg::FIFO_CW'(scg_pkg::FIFO_DEPTH))
    // records are only produced with room for two
    `ASRT_IMP(a_push_room, aclk, aresetn, push.cnt != 2'd0, room_ok)
    // a double push is a break record followed by the end-of-list record
    `ASRT_IMP(a_pair_order, aclk, aresetn, push.cnt == 2'd2,
              !push.rec_a.last_chain && push.rec_b.last_chain)
    // a lone end-of-list record into an empty queue is at the head next cycle
    `ASRT_NXT(a_num_restart, aclk, aresetn,
              push.cnt != 2'd0 && push.rec_b.last_chain && push.cnt == 2'd1 &&
              push.rec_a.last_chain && fifo_count == '0 && !m_ready,
              m_valid && m_last_chain)

endmodule
